// ----- rtl/tses_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the time sorted event store.
// Depends on nothing; every other file imports this package.
package tses_pkg;

  // Number of event cells in the chain.
  localparam int DEPTH = 64;
  // Width of an event count and of the stored_count field (holds DEPTH).
  localparam int CNT_W = 7;

  // Operation codes of the request beat.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_TRUNC  = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_CHECK  = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // Action code that an assign check looks for.
  localparam logic [2:0] ACT_ASSIGN = 3'd2;

  // Request beat.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] event_time;
    logic [7:0]  event_player;
    logic [2:0]  event_action;
    logic [31:0] event_target;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic [31:0]      out_time;
    logic [7:0]       out_player;
    logic [2:0]       out_action;
    logic [31:0]      out_target;
    logic             out_valid;
    logic             check_hit;
    logic             status;
    logic [CNT_W-1:0] stored_count;
    logic             last;
  } res_t;

  // One stored event.
  typedef struct packed {
    logic [31:0] ev_time;
    logic [7:0]  ev_player;
    logic [2:0]  ev_action;
    logic [31:0] ev_target;
  } entry_t;

  // What every cell does in the current cycle.
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_SCAN,
    CM_INSERT,
    CM_SHIFT,
    CM_ROTATE
  } cell_mode_t;

  // Control broadcast from the sequencer to the cell chain.
  typedef struct packed {
    cell_mode_t mode;
    entry_t     ev;
  } cell_ctl_t;

endpackage

// ----- rtl/time_sorted_event_store_top.sv -----
`timescale 1ns / 1ps
// Time sorted event store: a chain of DEPTH event cells run by a sequencer.
// Depends on tses_pkg, tses_cell and tses_ctrl.
//
// Usage: a request beat on req_valid/req_ready carries an opcode and an
// event or a time bound. Results leave on res_valid/res_ready, one beat per
// emitted event for pop and query, one beat otherwise; last marks the final
// beat of a request. Requests are taken one at a time, when the sequencer
// is idle. Every request passes a scan state, in which the cells compare
// their times, then a find state, which locates the boundaries, before a
// single-beat operation loads its result into the output register.
// A pop shifts the chain left once per sent beat. A query with at least
// one match rotates all stored events once through the head cell. When
// the receiver stalls, the result register holds its beat; a pop stops
// shifting, and a query stops rotating at a matching event, until the
// beat is taken. Reset empties the store at once: the fill count clears
// and no clearing pass runs over the cells.
module time_sorted_event_store_top
  import tses_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_ready,
  output res_t res_data
);

  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count;
  entry_t           entries [DEPTH];
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] after_vec;
  logic [DEPTH-1:0] from_vec;
  logic [DEPTH-1:0] hit_vec;

  // Sequencer.
  tses_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ctl       (ctl),
    .count     (count),
    .head      (entries[0]),
    .after_vec (after_vec),
    .from_vec  (from_vec),
    .hit_vec   (hit_vec)
  );

  // Chain of cells; each talks to its neighbors and sees the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_after;
    logic   right_occ;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = entries[0];
      assign left_after = 1'b0;
    end else begin : g_inner_left
      assign left_entry = entries[i-1];
      assign left_after = after_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[0];
      assign right_occ   = 1'b0;
    end else begin : g_inner_right
      assign right_entry = entries[i+1];
      assign right_occ   = occ[i+1];
    end

    tses_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .right_occ   (right_occ),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .head_entry  (entries[0]),
      .left_after  (left_after),
      .entry       (entries[i]),
      .after       (after_vec[i]),
      .from_lo     (from_vec[i]),
      .hit         (hit_vec[i])
    );
  end

endmodule

// ----- rtl/tses_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted event chain: holds one event and its compare flags.
// Depends on tses_pkg.
module tses_cell
  import tses_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  logic      right_occ,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  entry_t    head_entry,
  input  logic      left_after,
  output entry_t    entry,
  output logic      after,
  output logic      from_lo,
  output logic      hit
);

  // Flags are taken against the command event; the slot moves by mode.
  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      CM_SCAN: begin
        // Empty cells count as lying past any time bound.
        after   <= !occ || (entry.ev_time > ctl.ev.ev_time);
        from_lo <= !occ || (entry.ev_time >= ctl.ev.ev_time);
        hit     <= occ && (entry.ev_time == ctl.ev.ev_time) &&
                   (entry.ev_action == ACT_ASSIGN) &&
                   (entry.ev_target == ctl.ev.ev_target);
      end
      CM_INSERT: begin
        // Cells past the insert point take their left neighbor; the first
        // cell past it takes the new event.
        if (left_after) begin
          entry <= left_entry;
        end else if (after) begin
          entry <= ctl.ev;
        end
      end
      CM_SHIFT: begin
        entry <= right_entry;
      end
      CM_ROTATE: begin
        // The last occupied cell wraps around to the head.
        entry <= right_occ ? right_entry : head_entry;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/tses_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the event store: takes request beats, drives the cell chain
// and builds result beats in the output register. Depends on tses_pkg.
module tses_ctrl
  import tses_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req_data,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res_data,
  output cell_ctl_t        ctl,
  output logic [CNT_W-1:0] count,
  input  entry_t           head,
  input  logic [DEPTH-1:0] after_vec,
  input  logic [DEPTH-1:0] from_vec,
  input  logic [DEPTH-1:0] hit_vec
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_DONE,
    ST_POP,
    ST_QUERY
  } state_t;

  state_t           state;
  req_t             cmd;
  logic [CNT_W-1:0] pos_hi;
  logic [CNT_W-1:0] pos_lo;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] final_cnt;
  logic             res_hit;
  logic             res_status;
  logic             out_free;
  logic             in_window;
  logic             res_load;
  logic [CNT_W-1:0] hi_next;
  logic [CNT_W-1:0] lo_next;

  // Index of the first set flag of a monotone flag row, or DEPTH if none.
  function automatic logic [CNT_W-1:0] first_set(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0]         b;
    logic [$clog2(DEPTH)-1:0] idx;
    b   = v & ~(v << 1);
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (b[i]) begin
        idx = idx | ($clog2(DEPTH))'(i);
      end
    end
    first_set = (|v) ? CNT_W'(idx) : CNT_W'(DEPTH);
  endfunction

  // Packs one result beat.
  function automatic res_t make_res(input entry_t e, input logic has_ev,
                                    input logic chk, input logic stat,
                                    input logic [CNT_W-1:0] cnt,
                                    input logic lst);
    res_t r;
    r.out_time     = has_ev ? e.ev_time : '0;
    r.out_player   = has_ev ? e.ev_player : '0;
    r.out_action   = has_ev ? e.ev_action : '0;
    r.out_target   = has_ev ? e.ev_target : '0;
    r.out_valid    = has_ev;
    r.check_hit    = chk;
    r.status       = stat;
    r.stored_count = cnt;
    r.last         = lst;
    make_res = r;
  endfunction

  assign req_ready = (state == ST_IDLE);
  assign hi_next   = first_set(after_vec);
  assign lo_next   = first_set(from_vec);

  // Cell chain command for this cycle.
  always_comb begin
    out_free  = !res_valid || res_ready;
    in_window = (step >= pos_lo) && (step < pos_hi);
    res_load  = out_free && ((state == ST_DONE) || (state == ST_POP) ||
                             (state == ST_QUERY && in_window));
    ctl.mode  = CM_HOLD;
    ctl.ev.ev_time   = cmd.event_time;
    ctl.ev.ev_player = cmd.event_player;
    ctl.ev.ev_action = cmd.event_action;
    ctl.ev.ev_target = cmd.event_target;
    unique case (state)
      ST_SCAN: begin
        ctl.mode = CM_SCAN;
      end
      ST_FIND: begin
        if (cmd.opcode == OP_INSERT && count != CNT_W'(DEPTH)) begin
          ctl.mode = CM_INSERT;
        end
      end
      ST_POP: begin
        if (out_free) begin
          ctl.mode = CM_SHIFT;
        end
      end
      ST_QUERY: begin
        if (out_free || !in_window) begin
          ctl.mode = CM_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  // State, fill count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // A taken beat empties the register unless a new one is loaded.
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cmd   <= req_data;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          state <= ST_FIND;
        end
        ST_FIND: begin
          pos_hi     <= hi_next;
          pos_lo     <= lo_next;
          step       <= '0;
          res_hit    <= 1'b0;
          res_status <= 1'b0;
          state      <= ST_DONE;
          unique case (cmd.opcode)
            OP_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                res_status <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
            end
            OP_TRUNC: begin
              count <= hi_next;
            end
            OP_POP: begin
              if (hi_next != '0) begin
                remaining <= hi_next;
                final_cnt <= count - hi_next;
                state     <= ST_POP;
              end
            end
            OP_QUERY: begin
              if (hi_next != lo_next) begin
                state <= ST_QUERY;
              end
            end
            OP_CHECK: begin
              res_hit <= |hit_vec;
            end
            OP_CLEAR: begin
              count <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_data  <= make_res(head, 1'b0, res_hit, res_status, count, 1'b1);
            state     <= ST_IDLE;
          end
        end
        ST_POP: begin
          // The head leaves the chain one event per beat.
          if (out_free) begin
            res_valid <= 1'b1;
            res_data  <= make_res(head, 1'b1, 1'b0, 1'b0, final_cnt,
                                  remaining == CNT_W'(1));
            remaining <= remaining - 1'b1;
            count     <= count - 1'b1;
            if (remaining == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_QUERY: begin
          // A full rotation of the occupied cells; matching heads are sent.
          if (in_window && out_free) begin
            res_valid <= 1'b1;
            res_data  <= make_res(head, 1'b1, 1'b0, 1'b0, count,
                                  step == pos_hi - 1'b1);
          end
          if (out_free || !in_window) begin
            step <= step + 1'b1;
            if (step == count - 1'b1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the number of cells.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // A pop in progress always has an event left to send.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (remaining != '0))
    else $error("pop running with nothing left");

  // An insert into a store with room grows it by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND && cmd.opcode == OP_INSERT && count != CNT_W'(DEPTH))
    |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the store by one");

  // An accepted request is scanned in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_SCAN))
    else $error("accepted request not scanned");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench of the time sorted event store: directed table, then random traffic.
// Depends on tses_pkg and time_sorted_event_store_top; keeps its own copy of the store.
module tb_top;
  import tses_pkg::*;

  // Codes the package leaves unnamed.
  localparam logic [2:0] OP_RSVD6  = 3'd6;
  localparam logic [2:0] OP_RSVD7  = 3'd7;
  localparam logic [2:0] ACT_RATE  = 3'd0;
  localparam logic [2:0] ACT_SKILL = 3'd1;
  localparam logic [2:0] ACT_AIM   = 3'd3;
  localparam logic [2:0] ACT_NUKE  = 3'd4;
  localparam logic [2:0] ACT_MAX   = 3'd7;

  localparam int RESET_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 80;
  localparam int PHASE_ITEMS     = 58;
  localparam int BURST_AT        = 20;
  localparam int MAX_REPORTS     = 40;

  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res_data;
  logic hold_off_req = 1'b0;

  int tx_idle_pct = 25;
  int rx_idle_pct = 63;
  int mismatch_count = 0;
  int beat_count = 0;
  int cycle_count = 0;
  int unsigned tick_base = 1000;

  // Shadow copy of the store.
  entry_t store_ev[DEPTH];
  int     store_cnt = 0;

  res_t step_beats[$];
  res_t expected_beats[$];
  res_t want_beat;
  dir_row_t dir_rows[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  time_sorted_event_store_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int beat);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got 0x%0h want 0x%0h", beat, name, got, want));
  endtask

  // Number of leading events whose time is at or below the bound.
  function automatic int count_through(input logic [31:0] bound);
    int n;
    n = 0;
    while (n < store_cnt && store_ev[n].ev_time <= bound) n++;
    return n;
  endfunction

  function automatic res_t event_beat(input int idx);
    res_t b;
    b = '0;
    b.out_time   = store_ev[idx].ev_time;
    b.out_player = store_ev[idx].ev_player;
    b.out_action = store_ev[idx].ev_action;
    b.out_target = store_ev[idx].ev_target;
    b.out_valid  = 1'b1;
    return b;
  endfunction

  // Result beat with no event, as typed into the directed table.
  function automatic res_t plain_beat(input int cnt, input bit hit);
    res_t b;
    b = '0;
    b.check_hit    = hit;
    b.stored_count = CNT_W'(cnt);
    b.last         = 1'b1;
    return b;
  endfunction

  // Applies one request to the shadow store and leaves its beats in step_beats.
  function automatic void apply_to_store(input req_t r);
    res_t b;
    int   p;
    int   m;
    b = '0;
    step_beats.delete();
    case (r.opcode)
      OP_INSERT: begin
        if (store_cnt >= DEPTH) begin
          b.status = 1'b1;
        end else begin
          p = count_through(r.event_time);
          for (int j = store_cnt; j > p; j--) store_ev[j] = store_ev[j - 1];
          store_ev[p].ev_time   = r.event_time;
          store_ev[p].ev_player = r.event_player;
          store_ev[p].ev_action = r.event_action;
          store_ev[p].ev_target = r.event_target;
          store_cnt++;
        end
        step_beats = {step_beats, b};
      end
      OP_TRUNC: begin
        store_cnt = count_through(r.event_time);
        step_beats = {step_beats, b};
      end
      OP_POP: begin
        m = count_through(r.event_time);
        for (int j = 0; j < m; j++) step_beats = {step_beats, event_beat(j)};
        for (int j = m; j < store_cnt; j++) store_ev[j - m] = store_ev[j];
        store_cnt -= m;
        if (m == 0) step_beats = {step_beats, b};
      end
      OP_QUERY: begin
        for (int j = 0; j < store_cnt; j++) begin
          if (store_ev[j].ev_time == r.event_time) step_beats = {step_beats, event_beat(j)};
          else if (store_ev[j].ev_time > r.event_time) break;
        end
        if (step_beats.size() == 0) step_beats = {step_beats, b};
      end
      OP_CHECK: begin
        for (int j = 0; j < store_cnt; j++) begin
          if (store_ev[j].ev_time == r.event_time && store_ev[j].ev_action == ACT_ASSIGN &&
              store_ev[j].ev_target == r.event_target)
            b.check_hit = 1'b1;
        end
        step_beats = {step_beats, b};
      end
      OP_CLEAR: begin
        store_cnt = 0;
        step_beats = {step_beats, b};
      end
      default: begin
        step_beats = {step_beats, b};
      end
    endcase
    foreach (step_beats[i]) step_beats[i].stored_count = CNT_W'(store_cnt);
    step_beats[step_beats.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [31:0] t,
                                  input logic [7:0] player, input logic [2:0] action,
                                  input logic [31:0] target, input bit typed, input res_t want);
    dir_row_t row;
    row.req.opcode       = op;
    row.req.event_time   = t;
    row.req.event_player = player;
    row.req.event_action = action;
    row.req.event_target = target;
    row.typed = typed;
    row.want  = want;
    dir_rows = {dir_rows, row};
  endfunction

  // Mostly a time already stored or one near the current tick; now and then an extreme.
  function automatic logic [31:0] pick_time(input int pct_stored);
    int k;
    k = $urandom_range(0, 99);
    if (store_cnt > 0 && k < pct_stored)
      return store_ev[$urandom_range(0, store_cnt - 1)].ev_time;
    k = $urandom_range(0, 99);
    if (k < 70) return tick_base + $urandom_range(0, 3);
    if (k < 85) return $urandom;
    if (k < 92) return 32'h0000_0000;
    return 32'hFFFF_FFFF;
  endfunction

  // One random request, shaped like game traffic over advancing ticks.
  function automatic req_t next_random_req(input bit only_insert);
    req_t r;
    int   k;
    int   idx;
    if ($urandom_range(0, 99) < 20) tick_base += $urandom_range(1, 3);
    r.opcode       = OP_INSERT;
    r.event_time   = pick_time(15);
    r.event_player = 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 35) r.event_action = ACT_ASSIGN;
    else if (k < 95) r.event_action = 3'($urandom_range(ACT_RATE, ACT_NUKE));
    else r.event_action = 3'($urandom_range(ACT_NUKE + 1, ACT_MAX));
    r.event_target = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 15) : $urandom;
    if (!only_insert) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        r.opcode = OP_INSERT;
      end else if (k < 60) begin
        r.opcode     = OP_QUERY;
        r.event_time = pick_time(80);
      end else if (k < 72) begin
        r.opcode = OP_CHECK;
        if (store_cnt > 0 && $urandom_range(0, 99) < 80) begin
          idx = $urandom_range(0, store_cnt - 1);
          r.event_time   = store_ev[idx].ev_time;
          r.event_target = store_ev[idx].ev_target;
        end else begin
          r.event_time = pick_time(50);
        end
      end else if (k < 82) begin
        r.opcode     = OP_POP;
        r.event_time = pick_time(70);
      end else if (k < 90) begin
        r.opcode     = OP_TRUNC;
        r.event_time = pick_time(70);
      end else if (k < 93) begin
        r.opcode = OP_CLEAR;
      end else if (k < 95) begin
        r.opcode = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
      end else begin
        // Insert with any action code, legal or not.
        r.opcode       = OP_INSERT;
        r.event_action = 3'($urandom);
      end
    end
    return r;
  endfunction

  // Offers one beat, holds it until taken, then records what it should cause.
  task automatic drive_req(input req_t r, input bit typed, input res_t want);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    apply_to_store(r);
    if (typed) expected_beats = {expected_beats, want};
    else expected_beats = {expected_beats, step_beats};
  endtask

  // Stimulus: directed table, then three random phases with different idling.
  initial begin
    req_t r;
    int   fill_left;
    add_row(OP_QUERY, 32'h0, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(0, 1'b0));
    add_row(OP_POP, 32'hFFFF_FFFF, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(0, 1'b0));
    add_row(OP_CHECK, 32'h0, 8'h00, ACT_ASSIGN, 32'h0, 1'b1, plain_beat(0, 1'b0));
    add_row(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, ACT_NUKE, 32'hFFFF_FFFF, 1'b1, plain_beat(1, 1'b0));
    add_row(OP_INSERT, 32'h0, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(2, 1'b0));
    add_row(OP_INSERT, 32'd100, 8'h03, ACT_ASSIGN, 32'hDEAD_BEEF, 1'b1, plain_beat(3, 1'b0));
    add_row(OP_INSERT, 32'd100, 8'h07, ACT_SKILL, 32'd5, 1'b1, plain_beat(4, 1'b0));
    add_row(OP_INSERT, 32'd100, 8'h09, ACT_AIM, 32'd77, 1'b1, plain_beat(5, 1'b0));
    add_row(OP_INSERT, 32'd100, 8'hA5, ACT_MAX, 32'hDEAD_BEEF, 1'b1, plain_beat(6, 1'b0));
    add_row(OP_INSERT, 32'd100, 8'h5A, ACT_ASSIGN, 32'd5, 1'b1, plain_beat(7, 1'b0));
    // Same-tick events must come back in arrival order.
    add_row(OP_QUERY, 32'd100, 8'h00, ACT_RATE, 32'h0, 1'b0, '0);
    add_row(OP_CHECK, 32'd100, 8'h00, ACT_RATE, 32'hDEAD_BEEF, 1'b1, plain_beat(7, 1'b1));
    add_row(OP_CHECK, 32'd100, 8'h00, ACT_RATE, 32'd5, 1'b1, plain_beat(7, 1'b1));
    // An aim event never counts as assign, and a time with no stored event never hits.
    add_row(OP_CHECK, 32'd100, 8'h00, ACT_RATE, 32'd77, 1'b1, plain_beat(7, 1'b0));
    add_row(OP_CHECK, 32'd101, 8'h00, ACT_RATE, 32'hDEAD_BEEF, 1'b1, plain_beat(7, 1'b0));
    add_row(OP_RSVD6, 32'hFFFF_FFFF, 8'hFF, ACT_MAX, 32'hFFFF_FFFF, 1'b1, plain_beat(7, 1'b0));
    add_row(OP_RSVD7, 32'h0, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(7, 1'b0));
    add_row(OP_TRUNC, 32'd100, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(6, 1'b0));
    add_row(OP_TRUNC, 32'hFFFF_FFFF, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(6, 1'b0));
    add_row(OP_QUERY, 32'hFFFF_FFFF, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(6, 1'b0));
    add_row(OP_POP, 32'h0, 8'h00, ACT_RATE, 32'h0, 1'b0, '0);
    add_row(OP_POP, 32'd99, 8'h00, ACT_RATE, 32'h0, 1'b1, plain_beat(5, 1'b0));
    add_row(OP_POP, 32'hFFFF_FFFF, 8'h00, ACT_RATE, 32'h0, 1'b0, '0);
    add_row(OP_INSERT, 32'd42, 8'h11, ACT_ASSIGN, 32'd9, 1'b1, plain_beat(1, 1'b0));
    add_row(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF, ACT_MAX, 32'hFFFF_FFFF, 1'b1, plain_beat(0, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) drive_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // The fill burst may run on into the next phase.
    fill_left = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 63;
        end
        1: begin
          tx_idle_pct = 63;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_off_req <= 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Fill the store to the brim and push a few inserts past full.
        if (phase == 0 && n == BURST_AT) fill_left = DEPTH - store_cnt + 3;
        r = next_random_req(fill_left > 0);
        if (fill_left > 0) fill_left--;
        drive_req(r, 1'b0, '0);
      end
    end
    req_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("** time_sorted_event_store_top: PASSED **");
    else $display("** time_sorted_event_store_top: FAILED **");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    bit hold_off_done;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_count));
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("out_time", res_data.out_time, want_beat.out_time, beat_count);
        check_field("out_player", 32'(res_data.out_player), 32'(want_beat.out_player),
                    beat_count);
        check_field("out_action", 32'(res_data.out_action), 32'(want_beat.out_action),
                    beat_count);
        check_field("out_target", res_data.out_target, want_beat.out_target, beat_count);
        check_field("out_valid", 32'(res_data.out_valid), 32'(want_beat.out_valid),
                    beat_count);
        check_field("check_hit", 32'(res_data.check_hit), 32'(want_beat.check_hit),
                    beat_count);
        check_field("status", 32'(res_data.status), 32'(want_beat.status), beat_count);
        check_field("stored_count", 32'(res_data.stored_count),
                    32'(want_beat.stored_count), beat_count);
        check_field("last", 32'(res_data.last), 32'(want_beat.last), beat_count);
      end
      beat_count++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** time_sorted_event_store_top: FAILED **");
      $finish;
    end
  end

endmodule

// ----- files.f -----
rtl/tses_pkg.sv
rtl/tses_cell.sv
rtl/tses_ctrl.sv
rtl/time_sorted_event_store_top.sv
verif/tb_top.sv
